/* design/epoch_pin_table_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the epoch pin table
// Concurrent checks, clocked on a rising edge and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef EPOCH_PIN_TABLE_CORE_ASSERT_SVH
`define EPOCH_PIN_TABLE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define EPT_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define EPT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define EPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define EPT_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define EPT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define EPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* design/ept_pkg.sv */
// ---------------------------------------------------------------------------
// Epoch pin table package
// Request and result types, operation and status codes, fixed constants.
// ---------------------------------------------------------------------------
`default_nettype none

package ept_pkg;

	localparam int OP_W     = 3;
	localparam int STATUS_W = 2;
	localparam int SWEPT_W  = 5;
	localparam int PROD_W   = 52;

	// operation codes
	localparam logic [OP_W-1:0] OP_REGISTER = 3'd0;
	localparam logic [OP_W-1:0] OP_HAS      = 3'd1;
	localparam logic [OP_W-1:0] OP_RELEASE  = 3'd2;
	localparam logic [OP_W-1:0] OP_LEASE    = 3'd3;
	localparam logic [OP_W-1:0] OP_DROP     = 3'd4;
	localparam logic [OP_W-1:0] OP_FLOOR    = 3'd5;
	localparam logic [OP_W-1:0] OP_SWEEP    = 3'd6;
	localparam logic [OP_W-1:0] OP_ADVANCE  = 3'd7;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ABSENT       = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL         = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_NOT_ENROLLED = 2'd3;

	// configuration register indexes
	localparam logic REG_TTL_MS = 1'b0;

	localparam logic [19:0] NS_PER_MS   = 20'd1000000;
	localparam logic [31:0] TTL_RESET   = 32'd60000;
	localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] EPOCH_RESET = 64'd1;
	localparam logic [31:0] LEASE_MAX   = 32'hFFFF_FFFF;
	localparam logic [SWEPT_W-1:0] SWEPT_MAX = 5'd31;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [63:0]     pin_key;
		logic [63:0]     section_epoch;
		logic            enrolled;
		logic [63:0]     now_ns;
		logic [63:0]     thread_floor;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [63:0]         floor_epoch;
		logic [63:0]         active_out;
		logic [SWEPT_W-1:0]  swept_count;
	} rsp_t;

endpackage

`default_nettype wire

/* design/epoch_pin_table_core.sv */
// ---------------------------------------------------------------------------
// Epoch pin table core
// Table of transaction epoch pins with register, lookup, release, lease, drop,
// floor, sweep and epoch advance operations, built around one slot scanner.
// ---------------------------------------------------------------------------
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+---------------------------------
//  request   | req_valid / req_stall        | req (ept_pkg::req_t)
//  result    | rsp_valid / rsp_stall        | rsp (ept_pkg::rsp_t)
//  config    | psel/penable/pwrite, pready  | paddr, pwdata, prdata (ttl_ms)
//
//  Each slot is read in turn through the single read port, one slot read a
//  cycle, and judged from the read register; after the last slot is judged
//  the update is applied and the result loads. The scan of the read port is
//  the limit. A new request is taken only once the sequencer is back in idle.
//  Reset clears every valid bit at once; no clearing pass is needed.
//  A waiting result holds in its register while the next request is taken;
//  the update stage waits only if that result is still stalled.
//
`default_nettype none

`include "epoch_pin_table_core_assert.svh"

module epoch_pin_table_core
	import ept_pkg::*;
#(
	parameter int PIN_SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire req_t        req,

	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output rsp_t             rsp,

	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int IDX_W = (PIN_SLOTS > 1) ? $clog2(PIN_SLOTS) : 1;
	localparam int CNT_W = $clog2(PIN_SLOTS + 1);
	localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(PIN_SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIN_SLOTS - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_APPLY = 2'd2;

	// control
	logic [1:0]           state_q;
	logic [CNT_W-1:0]     rd_idx_q;
	logic                 ev_go_s1;
	logic [IDX_W-1:0]     ev_idx_s1;
	logic [PIN_SLOTS-1:0] valid_q;
	logic                 rsp_valid_q;
	logic [31:0]          ttl_q;
	logic [63:0]          global_epoch_q;
	logic [63:0]          active_q;

	// captured request and scan accumulators
	req_t                 req_q;
	logic [63:0]          floor_pre_q;
	logic [63:0]          floor_post_q;
	logic                 found_q;
	logic [IDX_W-1:0]     match_idx_q;
	logic [63:0]          match_epoch_q;
	logic [31:0]          match_leases_q;
	logic                 free_found_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic [SWEPT_W-1:0]   swept_q;
	logic [PROD_W-1:0]    prod_q;
	logic [63:0]          expiry_q;
	rsp_t                 rsp_q;

	// slot memories
	logic [63:0]          key_mem    [PIN_SLOTS];
	logic [63:0]          epoch_mem  [PIN_SLOTS];
	logic [63:0]          expiry_mem [PIN_SLOTS];
	logic [31:0]          leases_mem [PIN_SLOTS];
	logic [63:0]          rd_key_s1;
	logic [63:0]          rd_epoch_s1;
	logic [63:0]          rd_expiry_s1;
	logic [31:0]          rd_leases_s1;

	logic                 req_take;
	logic                 rd_go;
	logic                 sweep_op;
	logic                 ev_live;
	logic                 ev_hit;
	logic                 ev_remove;
	logic                 ev_keep;
	logic [64:0]          exp_sum;

	logic                 apply_go;
	logic [STATUS_W-1:0]  status_d;
	logic [63:0]          post_floor_d;
	logic [63:0]          active_d;
	logic [IDX_W-1:0]     wr_idx;
	logic                 key_we;
	logic                 epoch_we;
	logic                 expiry_we;
	logic                 leases_we;
	logic [63:0]          epoch_wdata;
	logic [31:0]          leases_wdata;
	logic                 set_valid;
	logic                 clr_valid;
	logic                 cfg_write;

	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// configuration port: one register, ttl_ms, at byte address 0
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_TTL_MS) ? ttl_q : 32'd0;

	// slot scan: issue one read per cycle, evaluate each slot from the read register
	assign rd_go    = (state_q == ST_SCAN) && (rd_idx_q < SLOT_CNT);
	assign sweep_op = (req_q.op == OP_SWEEP) || (req_q.op == OP_ADVANCE);
	assign ev_live  = ev_go_s1 && valid_q[ev_idx_s1];
	assign ev_hit   = ev_live && (rd_key_s1 == req_q.pin_key);
	// drop an expired, unleased pin when sweeping
	assign ev_remove = sweep_op && ev_live && (rd_expiry_s1 != 64'd0) &&
		(rd_expiry_s1 <= req_q.now_ns) && (rd_leases_s1 == 32'd0);
	// the floor after the request leaves out swept pins and a released key
	assign ev_keep = ev_live && !ev_remove && !((req_q.op == OP_RELEASE) && ev_hit);

	// expiry = now + ttl * 1e6, saturating; zero ttl means no expiry
	assign exp_sum = {1'b0, req_q.now_ns} + {13'd0, prod_q};

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(ttl_q) * PROD_W'(NS_PER_MS);
		if (ttl_q == 32'd0) begin
			expiry_q <= 64'd0;
		end else if (exp_sum[64]) begin
			expiry_q <= ALL_ONES;
		end else begin
			expiry_q <= exp_sum[63:0];
		end
	end

	// slot memories: read port for the scan, write port for the update
	always_ff @(posedge clk) begin
		if (rd_go) begin
			rd_key_s1    <= key_mem[rd_idx_q[IDX_W-1:0]];
			rd_epoch_s1  <= epoch_mem[rd_idx_q[IDX_W-1:0]];
			rd_expiry_s1 <= expiry_mem[rd_idx_q[IDX_W-1:0]];
			rd_leases_s1 <= leases_mem[rd_idx_q[IDX_W-1:0]];
		end
		if (apply_go && key_we) begin
			key_mem[wr_idx] <= req_q.pin_key;
		end
		if (apply_go && epoch_we) begin
			epoch_mem[wr_idx] <= epoch_wdata;
		end
		if (apply_go && expiry_we) begin
			expiry_mem[wr_idx] <= expiry_q;
		end
		if (apply_go && leases_we) begin
			leases_mem[wr_idx] <= leases_wdata;
		end
	end

	// update stage: decide status, writes, the reported floor and the watermark
	assign apply_go = (state_q == ST_APPLY) && !(rsp_valid_q && rsp_stall);

	always_comb begin
		status_d     = STATUS_OK;
		post_floor_d = floor_post_q;
		active_d     = active_q;
		wr_idx       = match_idx_q;
		key_we       = 1'b0;
		epoch_we     = 1'b0;
		expiry_we    = 1'b0;
		leases_we    = 1'b0;
		epoch_wdata  = req_q.section_epoch;
		leases_wdata = 32'd0;
		set_valid    = 1'b0;
		clr_valid    = 1'b0;
		case (req_q.op)
			OP_REGISTER: begin
				if (!req_q.enrolled) begin
					status_d = STATUS_NOT_ENROLLED;
				end else if (found_q || free_found_q) begin
					// keep the earlier epoch and refresh the expiry
					if (req_q.section_epoch < floor_post_q) begin
						post_floor_d = req_q.section_epoch;
					end
					epoch_we  = 1'b1;
					expiry_we = 1'b1;
					if (found_q) begin
						if (match_epoch_q < req_q.section_epoch) begin
							epoch_wdata = match_epoch_q;
						end
					end else begin
						wr_idx    = free_idx_q;
						key_we    = 1'b1;
						leases_we = 1'b1;
						set_valid = 1'b1;
					end
				end else begin
					status_d = STATUS_FULL;
				end
			end
			OP_HAS: begin
				status_d = found_q ? STATUS_OK : STATUS_ABSENT;
			end
			OP_RELEASE: begin
				if (found_q) begin
					clr_valid = 1'b1;
				end else begin
					status_d = STATUS_ABSENT;
				end
			end
			OP_LEASE: begin
				if (found_q) begin
					leases_we    = 1'b1;
					leases_wdata = (match_leases_q == LEASE_MAX) ?
						LEASE_MAX : match_leases_q + 32'd1;
				end else begin
					status_d = STATUS_ABSENT;
				end
			end
			OP_DROP: begin
				if (found_q) begin
					leases_we    = 1'b1;
					leases_wdata = (match_leases_q != 32'd0) ?
						match_leases_q - 32'd1 : 32'd0;
				end else begin
					status_d = STATUS_ABSENT;
				end
			end
			OP_ADVANCE: begin
				// watermark from the pin floor taken before the sweep
				active_d = (req_q.thread_floor < floor_pre_q) ?
					req_q.thread_floor : floor_pre_q;
			end
			default: begin
			end
		endcase
	end

	// scan accumulators and result register
	always_ff @(posedge clk) begin
		if (req_take) begin
			req_q        <= req;
			floor_pre_q  <= ALL_ONES;
			floor_post_q <= ALL_ONES;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			swept_q      <= '0;
		end else if (ev_go_s1) begin
			if (ev_live && (rd_epoch_s1 < floor_pre_q)) begin
				floor_pre_q <= rd_epoch_s1;
			end
			if (ev_keep && (rd_epoch_s1 < floor_post_q)) begin
				floor_post_q <= rd_epoch_s1;
			end
			if (ev_hit) begin
				found_q        <= 1'b1;
				match_idx_q    <= ev_idx_s1;
				match_epoch_q  <= rd_epoch_s1;
				match_leases_q <= rd_leases_s1;
			end
			if (!ev_live && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= ev_idx_s1;
			end
			if (ev_remove && (swept_q != SWEPT_MAX)) begin
				swept_q <= swept_q + SWEPT_W'(1);
			end
		end
		if (rd_go) begin
			ev_idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if (apply_go) begin
			rsp_q.status      <= status_d;
			rsp_q.floor_epoch <= post_floor_d;
			rsp_q.active_out  <= active_d;
			rsp_q.swept_count <= swept_q;
		end
	end

	// sequencer, valid bits and epoch registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			rd_idx_q       <= '0;
			ev_go_s1       <= 1'b0;
			valid_q        <= '0;
			rsp_valid_q    <= 1'b0;
			ttl_q          <= TTL_RESET;
			global_epoch_q <= EPOCH_RESET;
			active_q       <= EPOCH_RESET;
		end else begin
			if (cfg_write && (paddr[2] == REG_TTL_MS)) begin
				ttl_q <= pwdata;
			end
			if (apply_go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			ev_go_s1 <= rd_go;
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						rd_idx_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_go) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (ev_remove) begin
						valid_q[ev_idx_s1] <= 1'b0;
					end
					if (ev_go_s1 && (ev_idx_s1 == LAST_IDX)) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (apply_go) begin
						if (set_valid) begin
							valid_q[wr_idx] <= 1'b1;
						end
						if (clr_valid) begin
							valid_q[wr_idx] <= 1'b0;
						end
						if (req_q.op == OP_ADVANCE) begin
							global_epoch_q <= global_epoch_q + 64'd1;
						end
						active_q <= active_d;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a request only enters from idle, and the scan starts next
	`EPT_ASSERT_NEXT(a_take_scan, clk, arst_n, req_take, state_q == ST_SCAN, "request not scanned")

	// the scan only ever removes pins
	`EPT_ASSERT_NEXT(a_scan_no_add, clk, arst_n, state_q == ST_SCAN, $countones(valid_q) <= $past($countones(valid_q)), "pin added during scan")

	// only sweep and advance count removed pins
	`EPT_ASSERT_IMPLY(a_swept_op, clk, arst_n, (state_q == ST_APPLY) && !sweep_op, swept_q == '0, "swept count on non-sweep request")

	// slot writes happen only in the update stage
	`EPT_ASSERT_ALWAYS(a_write_stage, clk, arst_n, !(apply_go && (key_we || epoch_we || expiry_we || leases_we)) || (state_q == ST_APPLY), "slot write outside update")

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch pin table testbench
// Sends a short opening script and then several hundred random requests
// under a range of pin lifetimes. Every result is compared, field by field,
// against a behavioural copy of the pin table that runs in this bench, or against
// fixed values for the first opening rows. The sender and the receiver both pause
// at random, and the receiver holds off once for a long while so that the block backs up.
// ----------------------------------------------------------------------------

module tb;
	import ept_pkg::*;

	localparam int SLOTS           = 16;
	localparam int KEY_POOL        = 20;  // more keys than slots, so the table fills
	localparam int ITEMS_PER_PHASE = 90;
	localparam int PHASES          = 5;
	localparam int LONG_HOLD       = 300; // receiver hold-off, in cycles
	localparam int HOLD_AT_RESULT  = 150;
	localparam logic [2:0] TTL_ADDR = {REG_TTL_MS, 2'b00};

	typedef struct {
		req_t r;
		bit   fixed;  // when set, compare against want instead of the copy
		rsp_t want;
	} script_row_t;

	// ------------------------------------------------------------------------
	// Clock, reset and every block input, all known from time zero
	// ------------------------------------------------------------------------
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	req_t        req       = '0;
	logic        rsp_stall = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;

	logic        req_stall;
	logic        rsp_valid;
	rsp_t        rsp;
	logic [31:0] prdata;
	logic        pready;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	epoch_pin_table_core #(
		.PIN_SLOTS(SLOTS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// ------------------------------------------------------------------------
	// Behavioural copy of the pin table
	// ------------------------------------------------------------------------
	logic        pin_live   [SLOTS];
	logic [63:0] pin_key    [SLOTS];
	logic [63:0] pin_epoch  [SLOTS];
	logic [63:0] pin_expiry [SLOTS];
	logic [31:0] pin_leases [SLOTS];
	logic [63:0] epoch_count;
	logic [63:0] active_mark;
	logic [31:0] ttl_copy;

	rsp_t owed_results [$];   // results owed by the block, oldest first
	int   fault_count = 0;
	bit   tx_steady   = 1'b0; // sender offers back to back
	bit   rx_steady   = 1'b0; // receiver never stalls, bar the long hold

	// stimulus shaping
	logic [63:0] key_pool [KEY_POOL];
	logic [63:0] clock_ns;
	logic [63:0] epoch_hint;

	function automatic int find_pin(input logic [63:0] key);
		for (int i = 0; i < SLOTS; i++)
			if (pin_live[i] && pin_key[i] == key)
				return i;
		return -1;
	endfunction

	function automatic logic [63:0] lowest_epoch();
		logic [63:0] m = ALL_ONES;
		for (int i = 0; i < SLOTS; i++)
			if (pin_live[i] && pin_epoch[i] < m)
				m = pin_epoch[i];
		return m;
	endfunction

	// A zero lifetime stores expiry zero, which means "never expires";
	// otherwise the sum saturates at all ones.
	function automatic logic [63:0] expiry_at(input logic [63:0] now);
		logic [63:0] span;
		span = 64'(ttl_copy) * 64'(NS_PER_MS);
		if (ttl_copy == 0)
			return 64'd0;
		if (now > ALL_ONES - span)
			return ALL_ONES;
		return now + span;
	endfunction

	// Drop every unleased pin whose expiry has passed.
	function automatic int sweep_expired(input logic [63:0] now);
		int n = 0;
		for (int i = 0; i < SLOTS; i++) begin
			if (pin_live[i] && pin_expiry[i] != 0 && pin_expiry[i] <= now &&
			    pin_leases[i] == 0) begin
				pin_live[i] = 1'b0;
				n++;
			end
		end
		return n;
	endfunction

	// Apply one request to the copy and return the result it must produce.
	function automatic rsp_t apply_pin_op(input req_t r);
		rsp_t        o;
		int          s;
		int          n;
		logic [63:0] pf;
		o = '0;
		o.status = STATUS_OK;
		n = 0;
		case (r.op)
			OP_REGISTER: begin
				if (!r.enrolled) begin
					o.status = STATUS_NOT_ENROLLED;
				end else begin
					s = find_pin(r.pin_key);
					if (s >= 0) begin
						// keep the older epoch, refresh the expiry, keep the leases
						if (r.section_epoch < pin_epoch[s])
							pin_epoch[s] = r.section_epoch;
						pin_expiry[s] = expiry_at(r.now_ns);
					end else begin
						for (int i = SLOTS - 1; i >= 0; i--)
							if (!pin_live[i])
								s = i;
						if (s < 0) begin
							o.status = STATUS_FULL;
						end else begin
							pin_live[s]   = 1'b1;
							pin_key[s]    = r.pin_key;
							pin_epoch[s]  = r.section_epoch;
							pin_expiry[s] = expiry_at(r.now_ns);
							pin_leases[s] = '0;
						end
					end
				end
			end
			OP_HAS: begin
				if (find_pin(r.pin_key) < 0)
					o.status = STATUS_ABSENT;
			end
			OP_RELEASE: begin
				s = find_pin(r.pin_key);
				if (s < 0)
					o.status = STATUS_ABSENT;
				else
					pin_live[s] = 1'b0;
			end
			OP_LEASE: begin
				s = find_pin(r.pin_key);
				if (s < 0)
					o.status = STATUS_ABSENT;
				else if (pin_leases[s] != LEASE_MAX)
					pin_leases[s] = pin_leases[s] + 1;
			end
			OP_DROP: begin
				s = find_pin(r.pin_key);
				if (s < 0)
					o.status = STATUS_ABSENT;
				else if (pin_leases[s] != 0)
					pin_leases[s] = pin_leases[s] - 1;
			end
			OP_FLOOR: ;
			OP_SWEEP: begin
				n = sweep_expired(r.now_ns);
			end
			OP_ADVANCE: begin
				// the watermark takes the pin floor before the sweep runs
				epoch_count = epoch_count + 1;
				pf = lowest_epoch();
				active_mark = (r.thread_floor < pf) ? r.thread_floor : pf;
				n = sweep_expired(r.now_ns);
			end
		endcase
		if (n > SWEPT_MAX)
			n = SWEPT_MAX;
		o.floor_epoch = lowest_epoch();
		o.active_out  = active_mark;
		o.swept_count = n[SWEPT_W-1:0];
		return o;
	endfunction

	// ------------------------------------------------------------------------
	// Opening script rows
	// ------------------------------------------------------------------------
	function automatic script_row_t checked(input logic [2:0] op, input logic [63:0] key,
	                                       input logic [63:0] sec, input logic en,
	                                       input logic [63:0] now, input logic [63:0] thr);
		script_row_t w;
		w.r.op            = op;
		w.r.pin_key       = key;
		w.r.section_epoch = sec;
		w.r.enrolled      = en;
		w.r.now_ns        = now;
		w.r.thread_floor  = thr;
		w.fixed           = 1'b0;
		w.want            = '0;
		return w;
	endfunction

	function automatic script_row_t known(input logic [2:0] op, input logic [63:0] key,
	                                     input logic en, input logic [63:0] now,
	                                     input logic [63:0] thr, input logic [1:0] st,
	                                     input logic [63:0] fl, input logic [63:0] act);
		script_row_t w;
		w = checked(op, key, 64'd0, en, now, thr);
		w.fixed            = 1'b1;
		w.want.status      = st;
		w.want.floor_epoch = fl;
		w.want.active_out  = act;
		w.want.swept_count = '0;
		return w;
	endfunction

	// ------------------------------------------------------------------------
	// Random request, mostly on a small pool of keys so that pins are
	// registered, leased, dropped and released again; a few strays miss.
	// ------------------------------------------------------------------------
	function automatic req_t next_request();
		req_t        r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)      r.op = OP_REGISTER;
		else if (pick < 40) r.op = OP_HAS;
		else if (pick < 50) r.op = OP_RELEASE;
		else if (pick < 62) r.op = OP_LEASE;
		else if (pick < 72) r.op = OP_DROP;
		else if (pick < 78) r.op = OP_FLOOR;
		else if (pick < 88) r.op = OP_SWEEP;
		else                r.op = OP_ADVANCE;

		r.pin_key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
		                                         : key_pool[$urandom_range(0, KEY_POOL - 1)];
		epoch_hint = epoch_hint + 64'($urandom_range(0, 2));
		case ($urandom_range(0, 3))
			0:       r.section_epoch = {$urandom, $urandom};
			1:       r.section_epoch = 64'($urandom);
			default: r.section_epoch = epoch_hint + 64'($urandom_range(0, 8));
		endcase
		r.enrolled = ($urandom_range(0, 11) != 0);

		// advance time in small steps, with the odd long jump past expiry
		pick = $urandom_range(0, 19);
		if (pick == 0)
			clock_ns = clock_ns + 64'($urandom) * 64'($urandom_range(1, 20000));
		else
			clock_ns = clock_ns + 64'($urandom_range(0, 400000));
		r.now_ns = (pick == 1) ? {$urandom, $urandom} : clock_ns;

		case ($urandom_range(0, 9))
			0, 1, 2: r.thread_floor = ALL_ONES;
			3, 4, 5: r.thread_floor = {$urandom, $urandom};
			default: r.thread_floor = epoch_hint + 64'($urandom_range(0, 16));
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Request side: pause, offer, hold until taken, then log what is owed
	// ------------------------------------------------------------------------
	task automatic send_request(input req_t r, input bit fixed, input rsp_t want);
		int unsigned gap;
		rsp_t        owed;
		gap = tx_steady ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		owed = apply_pin_op(r);
		if (fixed)
			owed = want;
		owed_results = {owed_results, owed};
	endtask

	// Lower valid and wait until every owed result has come back.
	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
	endtask

	// Write the pin lifetime, then read it back.
	task automatic set_ttl(input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= TTL_ADDR;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		ttl_copy = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value) begin
			fault_count++;
			if (fault_count <= 10)
				$display("ttl_ms read back: want %h got %h", value, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Result side: check each result taken, then stall for a random count.
	// Once, hold off for a long stretch so the block fills and stalls its
	// request side.
	// ------------------------------------------------------------------------
	initial begin : result_side
		int unsigned wait_left;
		int unsigned hold_left;
		int unsigned taken;
		rsp_t        want;
		wait_left = 0;
		hold_left = 0;
		taken     = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				if (owed_results.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("stray result: status %0d floor %h active %h swept %0d",
						         rsp.status, rsp.floor_epoch, rsp.active_out,
						         rsp.swept_count);
				end else begin
					want = owed_results.pop_front();
					if (rsp.status !== want.status || rsp.floor_epoch !== want.floor_epoch ||
					    rsp.active_out !== want.active_out ||
					    rsp.swept_count !== want.swept_count) begin
						fault_count++;
						if (fault_count <= 10)
							$display({"result %0d: want status %0d floor %h active %h ",
							          "swept %0d, got status %0d floor %h active %h swept %0d"},
							         taken, want.status, want.floor_epoch, want.active_out,
							         want.swept_count, rsp.status, rsp.floor_epoch,
							         rsp.active_out, rsp.swept_count);
					end
				end
				taken++;
				wait_left = rx_steady ? 0 : $urandom_range(0, 5);
				if (taken == HOLD_AT_RESULT)
					hold_left = LONG_HOLD;
			end
			@(negedge clk);
			if (hold_left != 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else if (wait_left != 0) begin
				rsp_stall <= 1'b1;
				wait_left--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		script_row_t opening [$];
		logic [31:0] ttl_plan [PHASES];
		logic [63:0] k1;

		// copy starts in its reset state
		for (int i = 0; i < SLOTS; i++) begin
			pin_live[i]   = 1'b0;
			pin_key[i]    = '0;
			pin_epoch[i]  = '0;
			pin_expiry[i] = '0;
			pin_leases[i] = '0;
		end
		epoch_count = EPOCH_RESET;
		active_mark = EPOCH_RESET;
		ttl_copy    = TTL_RESET;

		key_pool[0] = 64'd0;
		key_pool[1] = ALL_ONES;
		for (int i = 2; i < KEY_POOL; i++)
			key_pool[i] = {$urandom, $urandom};
		epoch_hint = 64'($urandom);

		// lifetimes: never expire, the longest, the shortest, the reset value, any
		ttl_plan[0] = 32'd0;
		ttl_plan[1] = 32'hFFFF_FFFF;
		ttl_plan[2] = 32'd1;
		ttl_plan[3] = TTL_RESET;
		ttl_plan[4] = $urandom;

		k1 = 64'h8000_0000_0000_0001;
		// empty table: floor reads all ones, watermark at its reset value
		opening = {opening, known(OP_FLOOR, k1, 1'b1, 64'd0, 64'd0,
		                          STATUS_OK, ALL_ONES, EPOCH_RESET)};
		// register from outside a critical section is refused
		opening = {opening, known(OP_REGISTER, k1, 1'b0, 64'd0, 64'd0,
		                          STATUS_NOT_ENROLLED, ALL_ONES, EPOCH_RESET)};
		// every keyed lookup misses
		opening = {opening, known(OP_HAS, k1, 1'b1, 64'd0, 64'd0,
		                          STATUS_ABSENT, ALL_ONES, EPOCH_RESET)};
		opening = {opening, known(OP_RELEASE, k1, 1'b1, 64'd0, 64'd0,
		                          STATUS_ABSENT, ALL_ONES, EPOCH_RESET)};
		opening = {opening, known(OP_LEASE, k1, 1'b1, 64'd0, 64'd0,
		                          STATUS_ABSENT, ALL_ONES, EPOCH_RESET)};
		opening = {opening, known(OP_DROP, k1, 1'b1, 64'd0, 64'd0,
		                          STATUS_ABSENT, ALL_ONES, EPOCH_RESET)};
		opening = {opening, known(OP_SWEEP, k1, 1'b1, ALL_ONES, 64'd0,
		                          STATUS_OK, ALL_ONES, EPOCH_RESET)};
		// advance on an empty table: watermark follows the thread floor
		opening = {opening, known(OP_ADVANCE, k1, 1'b1, 64'd0, ALL_ONES,
		                          STATUS_OK, ALL_ONES, ALL_ONES)};
		opening = {opening, known(OP_ADVANCE, k1, 1'b1, 64'd0, 64'd0,
		                          STATUS_OK, ALL_ONES, 64'd0)};
		// expiry saturates at the top of time
		opening = {opening, checked(OP_REGISTER, 64'd0, ALL_ONES, 1'b1, ALL_ONES, 64'd0)};
		opening = {opening, checked(OP_REGISTER, ALL_ONES, 64'd0, 1'b1, 64'd0, 64'd0)};
		// re-register keeps the older epoch and refreshes the expiry
		opening = {opening, checked(OP_REGISTER, 64'd0, 64'd5, 1'b1, 64'd100, 64'd0)};
		opening = {opening, checked(OP_REGISTER, 64'd0, 64'd9, 1'b1, 64'd200, 64'd0)};
		opening = {opening, checked(OP_HAS, 64'd0, 64'd0, 1'b1, 64'd0, 64'd0)};
		// lease, drop, and a drop at zero leases
		opening = {opening, checked(OP_LEASE, ALL_ONES, 64'd0, 1'b1, 64'd0, 64'd0)};
		opening = {opening, checked(OP_DROP, ALL_ONES, 64'd0, 1'b1, 64'd0, 64'd0)};
		opening = {opening, checked(OP_DROP, ALL_ONES, 64'd0, 1'b1, 64'd0, 64'd0)};
		opening = {opening, checked(OP_LEASE, ALL_ONES, 64'd0, 1'b1, 64'd0, 64'd0)};
		// sweep spares the leased pin only
		opening = {opening, checked(OP_SWEEP, k1, 64'd0, 1'b1, ALL_ONES, 64'd0)};
		opening = {opening, checked(OP_REGISTER, k1, 64'd3, 1'b1, 64'd0, 64'd0)};
		// advance takes the floor before its sweep
		opening = {opening, checked(OP_ADVANCE, k1, 64'd0, 1'b1, ALL_ONES, ALL_ONES)};
		// release removes a pin even while leased
		opening = {opening, checked(OP_RELEASE, ALL_ONES, 64'd0, 1'b1, 64'd0, 64'd0)};
		opening = {opening, checked(OP_FLOOR, 64'd0, 64'd0, 1'b1, 64'd0, 64'd0)};

		// hold reset, then release it on a falling edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < opening.size(); i++)
			send_request(opening[i].r, opening[i].fixed, opening[i].want);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			tx_steady = (p == 1) || (p == 3);
			rx_steady = (p == 2) || (p == 3);
			set_ttl(ttl_plan[p]);
			clock_ns = {$urandom, $urandom} >> $urandom_range(0, 63);
			repeat (ITEMS_PER_PHASE)
				send_request(next_request(), 1'b0, '0);
			settle();
		end

		// let any stray result show itself before the verdict
		repeat (SLOTS + 8) @(posedge clk);
		if (fault_count == 0 && owed_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin : watchdog
		#800000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+design
design/ept_pkg.sv
design/epoch_pin_table_core.sv
verif/tb.sv
